// ----- design/pat_pkg.sv -----
// Shared types, register indexes, mode codes and the CORDIC arctangent table.
`default_nettype none

package pat_pkg;

   localparam int COORD_W = 32;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int MODE_W = 3;
   localparam int TURN_W = 16;
   localparam int ATAN_DEPTH = 32;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic [CSR_INDEX_W-1:0] csr_index_type;
   typedef logic [MODE_W-1:0] mode_type;

   // Configuration register indexes.
   localparam csr_index_type CSR_MODE = 3'd0;
   localparam csr_index_type CSR_OFFSET_X = 3'd1;
   localparam csr_index_type CSR_OFFSET_Y = 3'd2;
   localparam csr_index_type CSR_OFFSET_Z = 3'd3;
   localparam csr_index_type CSR_SCALE = 3'd4;
   localparam csr_index_type CSR_TURN = 3'd5;

   // Transform modes.
   localparam mode_type MODE_TRANSLATE = 3'd0;
   localparam mode_type MODE_SCALE = 3'd1;
   localparam mode_type MODE_ROT_X = 3'd2;
   localparam mode_type MODE_ROT_Y = 3'd3;
   localparam mode_type MODE_ROT_Z = 3'd4;

   // Arctangent of 2^-i in units of 2^-32 turn.
   localparam logic [31:0] ATAN_TURNS [ATAN_DEPTH] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
      32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
      32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
      32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
      32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
      32'h00000001, 32'h00000000
   };

   // CORDIC gain compensation, Q2.30.
   localparam logic signed [33:0] CORDIC_X0 = 34'sh026DD3B6A;

endpackage

`default_nettype wire

// ----- design/pat_if.sv -----
// Channel interfaces: point requests, transformed responses and register writes.
`default_nettype none

interface pat_req_if;
   logic valid;
   logic ready;
   pat_pkg::coord_type px;
   pat_pkg::coord_type py;
   pat_pkg::coord_type pz;
   modport source (output valid, output px, output py, output pz, input ready);
   modport sink (input valid, input px, input py, input pz, output ready);
endinterface

interface pat_rsp_if;
   logic valid;
   logic ready;
   pat_pkg::coord_type qx;
   pat_pkg::coord_type qy;
   pat_pkg::coord_type qz;
   logic overflow;
   modport source (output valid, output qx, output qy, output qz, output overflow,
                   input ready);
   modport sink (input valid, input qx, input qy, input qz, input overflow,
                 output ready);
endinterface

interface pat_csr_if;
   logic valid;
   logic ready;
   pat_pkg::csr_index_type index;
   logic [pat_pkg::CSR_DATA_W-1:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- design/point_affine_transform.sv -----
// Top level: streaming translate, scale or axis rotation of Q16.16 3D points.
// Points arrive on the req_bus channel (px, py, pz) and leave on rsp_bus
// (qx, qy, qz, overflow); each channel moves one transaction when valid and
// ready are both high on a rising clock edge. Register writes arrive on
// csr_bus as an index and 32 bits of data.
// The datapath is a four-stage pipeline: operand selection, multiply,
// sum and round, offset add and saturation. One point is accepted every
// cycle unless the receiver stalls or the CORDIC runs, so the rate is one
// transaction per cycle, set by one multiplier pair per coordinate lane.
// Each stage holds its own valid bit and moves when the stage after it is
// empty or moving, so a stalled receiver only stops the stages that are
// full; bubbles still close up and nothing is lost or repeated.
// Writing the turn fraction starts an iterative CORDIC; while it runs,
// req_bus and csr_bus are not ready.
// Synchronous reset empties the pipeline, sets mode to translation, all
// offsets to zero, the scale factor to 1.0, cosine to 1.0 and sine to zero.
`default_nettype none

module point_affine_transform #(
   parameter int TRIG_BITS = 16
) (
   input wire clock,
   input wire reset,
   pat_req_if.sink req_bus,
   pat_rsp_if.source rsp_bus,
   pat_csr_if.sink csr_bus
);

   localparam int PROD_W = 65;
   localparam int SUM_W = 66;
   localparam int RND_W = 50;
   localparam logic signed [31:0] UNIT_16 = 32'sd65536;
   localparam logic signed [31:0] UNIT_TB = 32'sd1 <<< TRIG_BITS;
   localparam logic signed [SUM_W-1:0] HALF_16 = 66'sd1 <<< 15;
   localparam logic signed [SUM_W-1:0] HALF_TB = 66'sd1 <<< (TRIG_BITS - 1);
   localparam logic signed [50:0] SAT_MAX = 51'sd2147483647;
   localparam logic signed [50:0] SAT_MIN = -51'sd2147483648;

   // Configuration registers.
   pat_pkg::mode_type mode_ff;
   pat_pkg::coord_type offset_ff [3];
   pat_pkg::coord_type scale_ff;
   logic csr_accept, trig_busy;
   logic signed [TRIG_BITS+1:0] cosine, sine;

   assign csr_accept = csr_bus.valid && csr_bus.ready;
   assign csr_bus.ready = !trig_busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= pat_pkg::MODE_TRANSLATE;
         offset_ff[0] <= '0;
         offset_ff[1] <= '0;
         offset_ff[2] <= '0;
         scale_ff <= UNIT_16;
      end else if (csr_accept) begin
         case (csr_bus.index)
            pat_pkg::CSR_MODE: mode_ff <= csr_bus.data[pat_pkg::MODE_W-1:0];
            pat_pkg::CSR_OFFSET_X: offset_ff[0] <= csr_bus.data;
            pat_pkg::CSR_OFFSET_Y: offset_ff[1] <= csr_bus.data;
            pat_pkg::CSR_OFFSET_Z: offset_ff[2] <= csr_bus.data;
            pat_pkg::CSR_SCALE: scale_ff <= csr_bus.data;
            default: begin
            end
         endcase
      end
   end

   // The angle itself is not kept; only its cosine and sine are.
   pat_cordic #(
      .TRIG_BITS(TRIG_BITS)
   ) u_cordic (
      .clock(clock),
      .reset(reset),
      .start(csr_accept && (csr_bus.index == pat_pkg::CSR_TURN)),
      .turn(csr_bus.data[pat_pkg::TURN_W-1:0]),
      .busy(trig_busy),
      .cosine(cosine),
      .sine(sine)
   );

   // Stage handshake: a stage loads when it is empty or its content moves on.
   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic en1, en2, en3, en4, req_accept;

   assign en4 = !v4_ff || rsp_bus.ready;
   assign en3 = !v3_ff || en4;
   assign en2 = !v2_ff || en3;
   assign en1 = !v1_ff || en2;
   assign req_bus.ready = en1 && !trig_busy;
   assign req_accept = req_bus.valid && req_bus.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= req_accept;
         if (en2) v2_ff <= v1_ff;
         if (en3) v3_ff <= v2_ff;
         if (en4) v4_ff <= v3_ff;
      end
   end

   // Stage 1 selects operands for each lane's a*m1 + b*m2, rounding and offset add.
   // Translation and pass-through use a unit multiplier so every mode shares
   // one datapath; rotation uses the trig fraction width for the rounding.
   logic signed [32:0] opa_in [3], opb_in [3], opa_ff [3], opb_ff [3];
   logic signed [31:0] opm1_in [3], opm2_in [3], opm1_ff [3], opm2_ff [3];
   pat_pkg::coord_type add_in [3], add1_ff [3], add2_ff [3], add3_ff [3];
   logic rot_in, rot1_ff, rot2_ff;
   logic signed [32:0] pt [3], diff [3];
   logic signed [31:0] cos32, sin32, nsin32;

   always_comb begin
      pt[0] = 33'(req_bus.px);
      pt[1] = 33'(req_bus.py);
      pt[2] = 33'(req_bus.pz);
      cos32 = 32'(cosine);
      sin32 = 32'(sine);
      nsin32 = -sin32;
      rot_in = 1'b0;
      for (int l = 0; l < 3; l++) begin
         diff[l] = pt[l] - 33'(offset_ff[l]);
         opa_in[l] = pt[l];
         opm1_in[l] = UNIT_16;
         opb_in[l] = '0;
         opm2_in[l] = '0;
         add_in[l] = '0;
      end
      case (mode_ff)
         pat_pkg::MODE_TRANSLATE: begin
            for (int l = 0; l < 3; l++) begin
               opa_in[l] = diff[l];
            end
         end
         pat_pkg::MODE_SCALE: begin
            for (int l = 0; l < 3; l++) begin
               opa_in[l] = diff[l];
               opm1_in[l] = scale_ff;
               add_in[l] = offset_ff[l];
            end
         end
         pat_pkg::MODE_ROT_X: begin
            rot_in = 1'b1;
            opm1_in[0] = UNIT_TB;
            opm1_in[1] = cos32;
            opb_in[1] = pt[2];
            opm2_in[1] = sin32;
            opm1_in[2] = cos32;
            opb_in[2] = pt[1];
            opm2_in[2] = nsin32;
         end
         pat_pkg::MODE_ROT_Y: begin
            rot_in = 1'b1;
            opm1_in[0] = cos32;
            opb_in[0] = pt[2];
            opm2_in[0] = sin32;
            opm1_in[1] = UNIT_TB;
            opm1_in[2] = cos32;
            opb_in[2] = pt[0];
            opm2_in[2] = nsin32;
         end
         pat_pkg::MODE_ROT_Z: begin
            rot_in = 1'b1;
            opm1_in[0] = cos32;
            opb_in[0] = pt[1];
            opm2_in[0] = sin32;
            opm1_in[1] = cos32;
            opb_in[1] = pt[0];
            opm2_in[1] = nsin32;
            opm1_in[2] = UNIT_TB;
         end
         default: begin
         end
      endcase
   end

   // Stage 2 multiplies, stage 3 sums and rounds, stage 4 adds the offset and saturates.
   logic signed [PROD_W-1:0] p1_ff [3], p2_ff [3], p1_in [3], p2_in [3];
   logic signed [SUM_W-1:0] sum [3], sh16 [3], shtb [3];
   logic signed [RND_W-1:0] rnd_in [3], rnd_ff [3];
   logic signed [50:0] total [3];
   pat_pkg::coord_type q_in [3], q_ff [3];
   logic [2:0] sat;
   logic ovf_ff;

   always_comb begin
      for (int l = 0; l < 3; l++) begin
         p1_in[l] = opa_ff[l] * opm1_ff[l];
         p2_in[l] = opb_ff[l] * opm2_ff[l];
         sum[l] = SUM_W'(p1_ff[l]) + SUM_W'(p2_ff[l]);
         sh16[l] = (sum[l] + HALF_16) >>> 16;
         shtb[l] = (sum[l] + HALF_TB) >>> TRIG_BITS;
         rnd_in[l] = rot2_ff ? shtb[l][RND_W-1:0] : sh16[l][RND_W-1:0];
         total[l] = 51'(rnd_ff[l]) + 51'(add3_ff[l]);
         if (total[l] > SAT_MAX) begin
            q_in[l] = 32'sh7FFF_FFFF;
            sat[l] = 1'b1;
         end else if (total[l] < SAT_MIN) begin
            q_in[l] = 32'sh8000_0000;
            sat[l] = 1'b1;
         end else begin
            q_in[l] = total[l][31:0];
            sat[l] = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en1 && req_accept) begin
         opa_ff <= opa_in;
         opb_ff <= opb_in;
         opm1_ff <= opm1_in;
         opm2_ff <= opm2_in;
         add1_ff <= add_in;
         rot1_ff <= rot_in;
      end
      if (en2 && v1_ff) begin
         p1_ff <= p1_in;
         p2_ff <= p2_in;
         add2_ff <= add1_ff;
         rot2_ff <= rot1_ff;
      end
      if (en3 && v2_ff) begin
         rnd_ff <= rnd_in;
         add3_ff <= add2_ff;
      end
      if (en4 && v3_ff) begin
         q_ff <= q_in;
         ovf_ff <= |sat;
      end
   end

   assign rsp_bus.valid = v4_ff;
   assign rsp_bus.qx = q_ff[0];
   assign rsp_bus.qy = q_ff[1];
   assign rsp_bus.qz = q_ff[2];
   assign rsp_bus.overflow = ovf_ff;

endmodule

`default_nettype wire

// ----- design/pat_cordic.sv -----
// Iterative CORDIC that turns a fraction of a turn into cosine and sine.
`default_nettype none

module pat_cordic #(
   parameter int TRIG_BITS = 16
) (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         start,
   input  wire [pat_pkg::TURN_W-1:0]   turn,
   output logic                        busy,
   output logic signed [TRIG_BITS+1:0] cosine,
   output logic signed [TRIG_BITS+1:0] sine
);

   localparam int STEPS = TRIG_BITS + 4;
   localparam int CW = $clog2(STEPS);
   localparam int SHIFT = 30 - TRIG_BITS;
   localparam logic signed [33:0] RND = 34'sd1 <<< (SHIFT - 1);
   localparam logic signed [33:0] ONE = 34'sd1 <<< TRIG_BITS;

   typedef enum logic [2:0] {
      TRIG_IDLE   = 3'b001,
      TRIG_RUN    = 3'b010,
      TRIG_FINISH = 3'b100
   } trig_state_type;

   trig_state_type state_ff, state_in;
   logic signed [33:0] x_ff, x_in, y_ff, y_in, z_ff, z_in;
   logic [CW-1:0] step_ff, step_in;
   logic neg_ff, neg_in;
   logic signed [TRIG_BITS+1:0] cosine_ff, cosine_in, sine_ff, sine_in;

   logic [31:0] angle, angle_biased, angle_fold;
   logic signed [33:0] xs, ys, at, xr, yr, xc, yc;

   always_comb begin
      angle = {turn, 16'h0000};
      angle_biased = angle + 32'h4000_0000;
      angle_fold = angle_biased[31] ? (angle ^ 32'h8000_0000) : angle;
      xs = x_ff >>> step_ff;
      ys = y_ff >>> step_ff;
      at = signed'({2'b00, pat_pkg::ATAN_TURNS[5'(step_ff)]});
      xr = (x_ff + RND) >>> SHIFT;
      yr = (y_ff + RND) >>> SHIFT;
      xc = (xr > ONE) ? ONE : ((xr < -ONE) ? -ONE : xr);
      yc = (yr > ONE) ? ONE : ((yr < -ONE) ? -ONE : yr);

      state_in = state_ff;
      x_in = x_ff;
      y_in = y_ff;
      z_in = z_ff;
      step_in = step_ff;
      neg_in = neg_ff;
      cosine_in = cosine_ff;
      sine_in = sine_ff;
      case (state_ff)
         TRIG_IDLE: begin
            if (start) begin
               x_in = pat_pkg::CORDIC_X0;
               y_in = '0;
               z_in = 34'(signed'(angle_fold));
               neg_in = angle_biased[31];
               step_in = '0;
               state_in = TRIG_RUN;
            end
         end
         TRIG_RUN: begin
            if (!z_ff[33]) begin
               x_in = x_ff - ys;
               y_in = y_ff + xs;
               z_in = z_ff - at;
            end else begin
               x_in = x_ff + ys;
               y_in = y_ff - xs;
               z_in = z_ff + at;
            end
            step_in = step_ff + 1'b1;
            if (step_ff == CW'(STEPS - 1)) begin
               state_in = TRIG_FINISH;
            end
         end
         TRIG_FINISH: begin
            cosine_in = neg_ff ? (TRIG_BITS+2)'(-xc) : (TRIG_BITS+2)'(xc);
            sine_in = neg_ff ? (TRIG_BITS+2)'(-yc) : (TRIG_BITS+2)'(yc);
            state_in = TRIG_IDLE;
         end
         default: begin
            state_in = TRIG_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= TRIG_IDLE;
         cosine_ff <= (TRIG_BITS+2)'(ONE);
         sine_ff <= '0;
      end else begin
         state_ff <= state_in;
         cosine_ff <= cosine_in;
         sine_ff <= sine_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in;
      y_ff <= y_in;
      z_ff <= z_in;
      step_ff <= step_in;
      neg_ff <= neg_in;
   end

   assign busy = (state_ff != TRIG_IDLE);
   assign cosine = cosine_ff;
   assign sine = sine_ff;

endmodule

`default_nettype wire

// ----- dv/testbench.sv -----
// Self-checking testbench for point_affine_transform: directed and random points against a model.
`timescale 1ns / 100ps

module testbench;

   // The block is built with its default trigonometric precision, and the
   // model below mirrors that width for cosine and sine.
   localparam int TRIG_BITS = 16;

   // The watchdog ends the run after this many cycles in which no
   // transaction moved on any channel. The longest legal quiet stretch is
   // the receiver hold-off.
   localparam int QUIET_LIMIT = 4000;
   localparam int RANDOM_POINTS = 1070;
   localparam int HOLD_OFF_CYCLES = 200;

   // Register indexes that the block does not implement; writes there must
   // leave every setting as it was.
   localparam pat_pkg::csr_index_type CSR_UNUSED_6 = 3'd6;
   localparam pat_pkg::csr_index_type CSR_UNUSED_7 = 3'd7;

   localparam pat_pkg::coord_type COORD_MAX = 32'sh7FFF_FFFF;
   localparam pat_pkg::coord_type COORD_MIN = 32'sh8000_0000;
   localparam pat_pkg::coord_type Q_ONE = 32'sh0001_0000;

   // Angles on both sides of the quarter-turn folding boundaries, the half turn and
   // the ends of the range.
   localparam logic [15:0] TURN_EDGES [7] = '{
      16'h0000, 16'h3FFF, 16'h4000, 16'h8000, 16'hBFFF, 16'hC000, 16'hFFFF
   };

   typedef struct packed {
      pat_pkg::coord_type qx;
      pat_pkg::coord_type qy;
      pat_pkg::coord_type qz;
      logic overflow;
   } point_result_type;

   logic clock;
   logic reset;

   pat_req_if req_bus ();
   pat_rsp_if rsp_bus ();
   pat_csr_if csr_bus ();

   point_affine_transform #(
      .TRIG_BITS(TRIG_BITS)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_bus(req_bus),
      .rsp_bus(rsp_bus),
      .csr_bus(csr_bus)
   );

   // Shadow copy of the register file and of the cached trigonometry.
   pat_pkg::mode_type cfg_mode;
   pat_pkg::coord_type cfg_offset_x;
   pat_pkg::coord_type cfg_offset_y;
   pat_pkg::coord_type cfg_offset_z;
   pat_pkg::coord_type cfg_scale;
   logic [pat_pkg::TURN_W-1:0] cfg_turn;
   logic signed [TRIG_BITS+1:0] cfg_cos;
   logic signed [TRIG_BITS+1:0] cfg_sin;

   // Transformed points that the block still owes, oldest first.
   point_result_type pending_points [$];

   int unsigned fail_count = 0;
   int unsigned points_sent = 0;
   int unsigned points_checked = 0;
   int unsigned csr_writes = 0;
   int unsigned saturated_points = 0;
   int unsigned random_points = 0;
   int unsigned mode_hits [8];
   int unsigned quiet_cycles = 0;
   int unsigned rsp_hold_cycles = 0;
   bit idle_on = 1'b1;

   // Free-running clock with a 2 ns period.
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Model of the datapath.
   // ---------------------------------------------------------------------

   // Adds one half of the last kept bit and shifts right with floor.
   function automatic longint round_shift_q(longint v, int sh);
      return (v + (longint'(1) << (sh - 1))) >>> sh;
   endfunction

   function automatic pat_pkg::coord_type clamp_coord(longint v);
      if (v > 64'sd2147483647) return COORD_MAX;
      if (v < -64'sd2147483648) return COORD_MIN;
      return pat_pkg::coord_type'(v);
   endfunction

   // Recomputes cosine and sine of the programmed angle with the same
   // CORDIC the block uses: the angle is folded into the right half plane,
   // rotated in Q2.30, rounded to the trig precision and clamped to +-1.0.
   function automatic void update_trig();
      logic [31:0] ang;
      logic [31:0] probe;
      bit flip;
      longint xr, yr, zr, nx, unit;
      int i;
      ang = {cfg_turn, 16'h0000};
      probe = ang + 32'h4000_0000;
      flip = probe[31];
      if (flip) ang = ang - 32'h8000_0000;
      zr = longint'($signed(ang));
      xr = longint'(pat_pkg::CORDIC_X0);
      yr = 0;
      for (i = 0; i < TRIG_BITS + 4 && i < pat_pkg::ATAN_DEPTH; i++) begin
         if (zr >= 0) begin
            nx = xr - (yr >>> i);
            yr = yr + (xr >>> i);
            zr = zr - longint'(pat_pkg::ATAN_TURNS[i]);
         end else begin
            nx = xr + (yr >>> i);
            yr = yr - (xr >>> i);
            zr = zr + longint'(pat_pkg::ATAN_TURNS[i]);
         end
         xr = nx;
      end
      unit = longint'(1) << TRIG_BITS;
      xr = round_shift_q(xr, 30 - TRIG_BITS);
      yr = round_shift_q(yr, 30 - TRIG_BITS);
      if (xr > unit) xr = unit;
      else if (xr < -unit) xr = -unit;
      if (yr > unit) yr = unit;
      else if (yr < -unit) yr = -unit;
      if (flip) begin
         xr = -xr;
         yr = -yr;
      end
      cfg_cos = xr[TRIG_BITS+1:0];
      cfg_sin = yr[TRIG_BITS+1:0];
   endfunction

   function automatic void reset_registers();
      cfg_mode = pat_pkg::MODE_TRANSLATE;
      cfg_offset_x = '0;
      cfg_offset_y = '0;
      cfg_offset_z = '0;
      cfg_scale = Q_ONE;
      cfg_turn = '0;
      cfg_cos = (TRIG_BITS+2)'(1 << TRIG_BITS);
      cfg_sin = '0;
   endfunction

   function automatic void apply_register(pat_pkg::csr_index_type idx,
                                          logic [pat_pkg::CSR_DATA_W-1:0] val);
      case (idx)
         pat_pkg::CSR_MODE: cfg_mode = val[pat_pkg::MODE_W-1:0];
         pat_pkg::CSR_OFFSET_X: cfg_offset_x = val;
         pat_pkg::CSR_OFFSET_Y: cfg_offset_y = val;
         pat_pkg::CSR_OFFSET_Z: cfg_offset_z = val;
         pat_pkg::CSR_SCALE: cfg_scale = val;
         pat_pkg::CSR_TURN: begin
            cfg_turn = val[pat_pkg::TURN_W-1:0];
            update_trig();
         end
         default: ;
      endcase
   endfunction

   // Every coordinate is formed exactly in 64 bits, rounded at most once and then
   // saturated; the overflow flag reports whether any lane was clamped.
   function automatic point_result_type transform_point(pat_pkg::coord_type px,
                                                        pat_pkg::coord_type py,
                                                        pat_pkg::coord_type pz);
      longint x, y, z, ox, oy, oz, k, c, s, rx, ry, rz;
      point_result_type r;
      x = px;
      y = py;
      z = pz;
      ox = cfg_offset_x;
      oy = cfg_offset_y;
      oz = cfg_offset_z;
      k = cfg_scale;
      c = cfg_cos;
      s = cfg_sin;
      rx = x;
      ry = y;
      rz = z;
      case (cfg_mode)
         pat_pkg::MODE_TRANSLATE: begin
            rx = x - ox;
            ry = y - oy;
            rz = z - oz;
         end
         pat_pkg::MODE_SCALE: begin
            rx = round_shift_q((x - ox) * k, 16) + ox;
            ry = round_shift_q((y - oy) * k, 16) + oy;
            rz = round_shift_q((z - oz) * k, 16) + oz;
         end
         pat_pkg::MODE_ROT_X: begin
            ry = round_shift_q(c * y + s * z, TRIG_BITS);
            rz = round_shift_q(c * z - s * y, TRIG_BITS);
         end
         pat_pkg::MODE_ROT_Y: begin
            rx = round_shift_q(c * x + s * z, TRIG_BITS);
            rz = round_shift_q(c * z - s * x, TRIG_BITS);
         end
         pat_pkg::MODE_ROT_Z: begin
            rx = round_shift_q(c * x + s * y, TRIG_BITS);
            ry = round_shift_q(c * y - s * x, TRIG_BITS);
         end
         default: ;
      endcase
      r.qx = clamp_coord(rx);
      r.qy = clamp_coord(ry);
      r.qz = clamp_coord(rz);
      r.overflow = (longint'(r.qx) != rx) || (longint'(r.qy) != ry) ||
                   (longint'(r.qz) != rz);
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // Channel drivers. Inputs change only at the falling edge and every
   // handshake is sampled at the rising edge, so nothing races the block.
   // ---------------------------------------------------------------------

   // Offers one point and waits for its transaction. Valid is left high so
   // that back-to-back points stream at full rate; whoever runs next lowers
   // it at the same falling edge if no further point follows.
   task automatic send_point(pat_pkg::coord_type px, pat_pkg::coord_type py,
                             pat_pkg::coord_type pz);
      point_result_type want;
      if (idle_on && $urandom_range(99) < 7) begin
         req_bus.valid = 1'b0;
         @(negedge clock);
      end
      req_bus.valid = 1'b1;
      req_bus.px = px;
      req_bus.py = py;
      req_bus.pz = pz;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      want = transform_point(px, py, pz);
      pending_points.push_back(want);
      points_sent++;
      mode_hits[cfg_mode]++;
      if (want.overflow) saturated_points++;
      @(negedge clock);
   endtask

   // Stops offering points and waits until the block has returned every
   // transformed point it owes. Since each point yields exactly one result,
   // an empty queue means the pipeline is empty too.
   task automatic drain_results();
      req_bus.valid = 1'b0;
      while (pending_points.size() != 0) @(negedge clock);
   endtask

   // Register writes are only issued while the block is idle. A turn write
   // starts the CORDIC, which holds ready low; the next write waits for it.
   task automatic write_reg(pat_pkg::csr_index_type idx,
                            logic [pat_pkg::CSR_DATA_W-1:0] val);
      csr_bus.valid = 1'b1;
      csr_bus.index = idx;
      csr_bus.data = val;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      apply_register(idx, val);
      csr_writes++;
      @(negedge clock);
      csr_bus.valid = 1'b0;
   endtask

   function automatic pat_pkg::coord_type pick_coord();
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 5) return COORD_MIN;
      if (roll < 10) return COORD_MAX;
      if (roll < 35)
         return pat_pkg::coord_type'($urandom_range(0, 32'h3F_FFFF)) - 32'sh20_0000;
      return pat_pkg::coord_type'($urandom);
   endfunction

   function automatic pat_pkg::coord_type pick_offset();
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 10) return '0;
      if (roll < 20) return COORD_MAX;
      if (roll < 30) return COORD_MIN;
      if (roll < 60)
         return pat_pkg::coord_type'($urandom_range(0, 32'h3F_FFFF)) - 32'sh20_0000;
      return pat_pkg::coord_type'($urandom);
   endfunction

   // ---------------------------------------------------------------------
   // Receiver: ready idles at random, except during the quiet stretch and
   // while a hold-off is counting down.
   // ---------------------------------------------------------------------
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold_cycles > 0) begin
            rsp_bus.ready = 1'b0;
            rsp_hold_cycles--;
         end else if (idle_on && $urandom_range(99) < 7) begin
            rsp_bus.ready = 1'b0;
         end else begin
            rsp_bus.ready = 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Result checker: every response transaction is compared with the
   // oldest owed point, field by field.
   // ---------------------------------------------------------------------
   task automatic note_failure(string msg);
      fail_count++;
      if (fail_count <= 10) $display("ERROR %0t ns: %s", $realtime, msg);
   endtask

   always @(posedge clock) begin : check_results
      point_result_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_points.size() == 0) begin
            note_failure($sformatf("unexpected point qx=%h qy=%h qz=%h overflow=%b",
                                   rsp_bus.qx, rsp_bus.qy, rsp_bus.qz, rsp_bus.overflow));
         end else begin
            want = pending_points.pop_front();
            points_checked++;
            if (rsp_bus.qx !== want.qx || rsp_bus.qy !== want.qy ||
                rsp_bus.qz !== want.qz || rsp_bus.overflow !== want.overflow) begin
               note_failure($sformatf(
                  "point %0d: expected %h %h %h ovf %b, got %h %h %h ovf %b",
                  points_checked, want.qx, want.qy, want.qz, want.overflow,
                  rsp_bus.qx, rsp_bus.qy, rsp_bus.qz, rsp_bus.overflow));
            end
         end
      end
   end

   // Watchdog: counts cycles in which no transaction moved on any channel.
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          (csr_bus.valid && csr_bus.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Watchdog: no transaction for %0d cycles, %0d points still owed",
                  quiet_cycles, pending_points.size());
         $display("point_affine_transform verification failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Test tasks.
   // ---------------------------------------------------------------------

   // Straight after reset the block translates by zero, so points pass
   // through unchanged, including the extremes of the coordinate range.
   task automatic test_reset_state();
      send_point('0, '0, '0);
      send_point(COORD_MAX, COORD_MIN, -32'sd1);
      send_point(Q_ONE, -Q_ONE, 32'sh1234_5678);
   endtask

   // Translation with extreme offsets saturates in both directions.
   task automatic test_translate();
      drain_results();
      write_reg(pat_pkg::CSR_MODE, 32'(pat_pkg::MODE_TRANSLATE));
      write_reg(pat_pkg::CSR_OFFSET_X, COORD_MAX);
      write_reg(pat_pkg::CSR_OFFSET_Y, COORD_MIN);
      write_reg(pat_pkg::CSR_OFFSET_Z, 3 * Q_ONE);
      send_point(COORD_MIN, COORD_MAX, '0);
      send_point(COORD_MAX, COORD_MIN, COORD_MIN);
   endtask

   // Scaling about a point: fractional, extreme, zero and negative factors,
   // plus a factor of one half that lands exactly on rounding ties.
   task automatic test_scale();
      drain_results();
      write_reg(pat_pkg::CSR_MODE, 32'(pat_pkg::MODE_SCALE));
      write_reg(pat_pkg::CSR_OFFSET_X, Q_ONE);
      write_reg(pat_pkg::CSR_OFFSET_Y, -Q_ONE);
      write_reg(pat_pkg::CSR_OFFSET_Z, '0);
      write_reg(pat_pkg::CSR_SCALE, 32'h0002_8000);
      send_point(3 * Q_ONE, 32'sd5, -7 * Q_ONE);
      drain_results();
      write_reg(pat_pkg::CSR_SCALE, COORD_MAX);
      send_point(COORD_MAX, COORD_MIN, Q_ONE);
      drain_results();
      write_reg(pat_pkg::CSR_SCALE, COORD_MIN);
      send_point(2 * Q_ONE, -Q_ONE, COORD_MIN);
      drain_results();
      write_reg(pat_pkg::CSR_SCALE, '0);
      send_point(32'sh0123_4567, -32'sh0765_4321, COORD_MAX);
      drain_results();
      write_reg(pat_pkg::CSR_SCALE, 32'h0000_8000);
      send_point(Q_ONE + 32'sd1, -32'sd1, 32'sd3);
   endtask

   // Each rotation axis at the folding boundaries of the angle, then at
   // 45 degrees with full-scale points so the rotated sum saturates.
   task automatic test_rotations();
      int i;
      for (i = 0; i < 7; i++) begin
         drain_results();
         write_reg(pat_pkg::CSR_MODE, 32'(pat_pkg::MODE_ROT_X + i % 3));
         write_reg(pat_pkg::CSR_TURN, 32'(TURN_EDGES[i]));
         send_point(3 * Q_ONE, -5 * Q_ONE, 7 * Q_ONE + 32'sd123);
      end
      drain_results();
      write_reg(pat_pkg::CSR_TURN, 32'h0000_2000);
      for (i = 0; i < 3; i++) begin
         drain_results();
         write_reg(pat_pkg::CSR_MODE, 32'(pat_pkg::MODE_ROT_X + i));
         send_point(COORD_MAX, COORD_MAX, COORD_MAX);
      end
   endtask

   // Mode codes above the rotations pass the point through untouched even
   // with offsets and an angle programmed.
   task automatic test_unused_modes();
      int i;
      drain_results();
      write_reg(pat_pkg::CSR_OFFSET_X, 32'sh0005_0000);
      write_reg(pat_pkg::CSR_TURN, 32'h0000_1234);
      for (i = 5; i < 8; i++) begin
         drain_results();
         write_reg(pat_pkg::CSR_MODE, 32'(i));
         send_point(COORD_MAX, COORD_MIN, pick_coord());
      end
   endtask

   // Writes to unimplemented indexes must not disturb any register.
   task automatic test_unknown_index();
      drain_results();
      write_reg(pat_pkg::CSR_MODE, 32'(pat_pkg::MODE_TRANSLATE));
      write_reg(CSR_UNUSED_6, $urandom);
      write_reg(CSR_UNUSED_7, $urandom);
      send_point(32'sh0010_0000, -32'sh0020_0000, 32'sh7000_0000);
   endtask

   // The receiver stops for a long stretch while points keep coming, so
   // the pipeline fills and the block must stall its input.
   task automatic test_backpressure();
      int n;
      drain_results();
      write_reg(pat_pkg::CSR_MODE, 32'(pat_pkg::MODE_ROT_Z));
      write_reg(pat_pkg::CSR_TURN, 32'h0000_2AAA);
      rsp_hold_cycles = HOLD_OFF_CYCLES;
      for (n = 0; n < 40; n++) send_point(pick_coord(), pick_coord(), pick_coord());
   endtask

   // The sender goes quiet until the block has emptied, then resumes with
   // the same settings.
   task automatic test_sender_pause();
      int n;
      drain_results();
      repeat (6) @(negedge clock);
      for (n = 0; n < 20; n++) send_point(pick_coord(), pick_coord(), pick_coord());
   endtask

   // Random phases: fresh settings, then a burst of random points. Mode
   // writes sometimes, and turn writes always, carry junk in the unused upper
   // data bits. One long phase runs with no idling on either side.
   task automatic test_random_phases();
      int phase, phase_len, n;
      logic [pat_pkg::CSR_DATA_W-1:0] word;
      pat_pkg::mode_type m;
      phase = 0;
      while (random_points < RANDOM_POINTS) begin
         drain_results();
         idle_on = (phase != 2);
         if ($urandom_range(99) < 8) m = pat_pkg::mode_type'($urandom_range(5, 7));
         else m = pat_pkg::mode_type'($urandom_range(0, 4));
         word = $urandom;
         word[pat_pkg::MODE_W-1:0] = m;
         write_reg(pat_pkg::CSR_MODE, ($urandom_range(3) == 0) ? word : 32'(m));
         write_reg(pat_pkg::CSR_OFFSET_X, pick_offset());
         write_reg(pat_pkg::CSR_OFFSET_Y, pick_offset());
         write_reg(pat_pkg::CSR_OFFSET_Z, pick_offset());
         // Mostly factors within +-8.0 so that scaled points do not all
         // saturate; now and then anything at all.
         if (m == pat_pkg::MODE_SCALE && $urandom_range(4) != 0)
            word = 32'($urandom_range(0, 32'h10_0000)) - 32'h8_0000;
         else
            word = $urandom;
         write_reg(pat_pkg::CSR_SCALE, word);
         word = $urandom;
         if ($urandom_range(3) == 0) word[15:0] = TURN_EDGES[$urandom_range(6)];
         write_reg(pat_pkg::CSR_TURN, word);
         if ($urandom_range(9) == 0)
            write_reg($urandom_range(1) ? CSR_UNUSED_6 : CSR_UNUSED_7, $urandom);
         phase_len = (phase == 2) ? 150 : $urandom_range(30, 80);
         for (n = 0; n < phase_len; n++) send_point(pick_coord(), pick_coord(), pick_coord());
         random_points += phase_len;
         phase++;
      end
      idle_on = 1'b1;
   endtask

   // ---------------------------------------------------------------------
   // Main sequence.
   // ---------------------------------------------------------------------
   initial begin
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.px = '0;
      req_bus.py = '0;
      req_bus.pz = '0;
      csr_bus.valid = 1'b0;
      csr_bus.index = '0;
      csr_bus.data = '0;
      foreach (mode_hits[i]) mode_hits[i] = 0;
      reset_registers();
      repeat (12) @(negedge clock);
      reset = 1'b0;

      test_reset_state();
      test_translate();
      test_scale();
      test_rotations();
      test_unused_modes();
      test_unknown_index();
      test_backpressure();
      test_sender_pause();
      test_random_phases();

      drain_results();
      repeat (12) @(negedge clock);
      if (pending_points.size() != 0)
         note_failure($sformatf("%0d points never returned", pending_points.size()));

      $display("Run covered %0d points, %0d of them saturating, and %0d register writes.",
               points_sent, saturated_points, csr_writes);
      $display("Points per mode 0..7: %0d %0d %0d %0d %0d %0d %0d %0d; %0d failures.",
               mode_hits[0], mode_hits[1], mode_hits[2], mode_hits[3], mode_hits[4],
               mode_hits[5], mode_hits[6], mode_hits[7], fail_count);
      if (fail_count == 0) begin
         $display("point_affine_transform verification clean");
      end else begin
         $display("point_affine_transform verification failed");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
design/pat_pkg.sv
design/pat_if.sv
design/pat_cordic.sv
design/point_affine_transform.sv
dv/testbench.sv
